>>> rtl/binary_min_heap_queue_macros.svh
// Assertion macros for the binary min-heap queue
`ifndef BINARY_MIN_HEAP_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define BMHQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define BMHQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bmhq_pkg.sv
// Types and constants shared by the binary min-heap queue modules
package bmhq_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 9;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  localparam logic signed [KEY_W-1:0] EMPTY_KEY = -32'sd1;

  typedef struct packed {
    logic                    kind;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] popped_key;
    logic                    pop_was_empty;
    logic                    insert_dropped;
    logic signed [KEY_W-1:0] current_min;
    logic [COUNT_W-1:0]      entry_count;
    logic                    heap_empty;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_LAST,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_UP_RD,
    CMD_UP_CMP,
    CMD_DN_LAST,
    CMD_DN_RD,
    CMD_DN_CMP,
    CMD_FINISH
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_root;
    logic leaf;
    logic up_lt;
    logic dn_lt;
  } dp_status_t;

endpackage

>>> rtl/binary_min_heap_queue.sv
// Binary min-heap priority queue of signed 32-bit keys
//
// Usage: present an operation on in_item and raise start; it is taken at a
// clock edge where busy is low. kind selects insert (key is appended and
// sifted up) or pop (the minimum is removed, the last entry moves to the
// root and sifts down, taking the smaller child, the right one on a tie).
// Exactly one result per transaction appears on out_item for a single cycle
// with out_valid high: the popped key, the empty-pop and full-insert flags,
// the new minimum, the entry count and an empty flag.
// Each heap level is walked as a registered memory read, then a compare and
// write back. An insert climbs until it reaches the root or a compare stops
// it; a pop sinks until it reaches a leaf or a compare stops it. With 256
// entries an insert makes at most 8 swaps and a pop at most 7. A pop of the
// last entry skips the sift down; an empty pop or a full insert goes
// straight to the result.
// busy stays high until the result strobe, so the next transaction is taken
// in the strobe cycle. Reset empties the heap at once; no clearing pass runs.
// The receiver cannot stall: the result is present for one cycle only.
module binary_min_heap_queue #(
  parameter int CAPACITY = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  bmhq_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output bmhq_pkg::out_item_t  out_item
);
  import bmhq_pkg::*;

  `include "binary_min_heap_queue_macros.svh"

  dp_cmd_t    cmd;
  dp_status_t status;

  bmhq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_item.kind),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  bmhq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `BMHQ_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `BMHQ_ASSERT_IMP(a_result_idle, out_valid, !busy, "result strobe while still busy")
  `BMHQ_ASSERT_IMP(a_flags_excl, out_valid, !(out_item.pop_was_empty && out_item.insert_dropped), "both empty-pop and dropped-insert flags set")
  `BMHQ_ASSERT_IMP(a_empty_pop_key, out_valid && out_item.pop_was_empty, out_item.popped_key == EMPTY_KEY, "empty pop returned a key")

endmodule

>>> rtl/bmhq_ctrl.sv
// Sequencer for the insert and pop sift walks
module bmhq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  in_kind,
  input  bmhq_pkg::dp_status_t  status,
  output bmhq_pkg::dp_cmd_t     cmd,
  output logic                  busy
);
  import bmhq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NOP;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd = CMD_LOAD;
          if (in_kind == KIND_POP) begin
            state_nxt = status.empty ? ST_FIN : ST_DN_LAST;
          end else begin
            state_nxt = status.full ? ST_FIN : ST_UP_RD;
          end
        end
      end
      ST_UP_RD: begin
        cmd       = CMD_UP_RD;
        state_nxt = status.pos_root ? ST_FIN : ST_UP_CMP;
      end
      ST_UP_CMP: begin
        cmd       = CMD_UP_CMP;
        state_nxt = status.up_lt ? ST_UP_RD : ST_FIN;
      end
      ST_DN_LAST: begin
        cmd       = CMD_DN_LAST;
        state_nxt = status.empty ? ST_FIN : ST_DN_RD;
      end
      ST_DN_RD: begin
        cmd       = CMD_DN_RD;
        state_nxt = status.leaf ? ST_FIN : ST_DN_CMP;
      end
      ST_DN_CMP: begin
        cmd       = CMD_DN_CMP;
        state_nxt = status.dn_lt ? ST_DN_RD : ST_FIN;
      end
      ST_FIN: begin
        cmd       = CMD_FINISH;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/bmhq_dp.sv
// Heap storage, sift registers, comparators and result register
module bmhq_dp #(
  parameter int CAPACITY = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bmhq_pkg::dp_cmd_t     cmd,
  input  bmhq_pkg::in_item_t    in_item,
  output bmhq_pkg::dp_status_t  status,
  output logic                  out_valid,
  output bmhq_pkg::out_item_t   out_item
);
  import bmhq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [KEY_W-1:0] mem [CAPACITY];

  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           pos_r, pos_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [KEY_W-1:0] root_r;
  logic signed [KEY_W-1:0] popped_r, popped_nxt;
  logic                    was_empty_r, was_empty_nxt;
  logic                    dropped_r, dropped_nxt;
  logic signed [KEY_W-1:0] rd_a_r, rd_b_r;
  logic                    out_valid_r;
  out_item_t               out_r;

  logic [AW-1:0]           ra_a, ra_b, wa;
  logic                    we;
  logic signed [KEY_W-1:0] wd;

  logic [CW:0]             left;
  logic [CW:0]             left_m1;
  logic [CW-1:0]           parent;
  logic [CW-1:0]           pos_m1;
  logic [CW-1:0]           cnt_m1;
  logic                    only_left;
  logic                    pick_left;
  logic signed [KEY_W-1:0] cval;
  logic [CW:0]             child;

  assign left      = {pos_r, 1'b0};
  assign left_m1   = left - 1'b1;
  assign parent    = pos_r >> 1;
  assign pos_m1    = pos_r - 1'b1;
  assign cnt_m1    = cnt_r - 1'b1;
  assign only_left = (left == {1'b0, cnt_r});
  assign pick_left = only_left || (rd_a_r < rd_b_r);
  assign cval      = pick_left ? rd_a_r : rd_b_r;
  assign child     = pick_left ? left : left + 1'b1;

  always_comb begin
    status.full     = (cnt_r == CW'(CAPACITY));
    status.empty    = (cnt_r == '0);
    status.pos_root = (pos_r == CW'(1));
    status.leaf     = (left > {1'b0, cnt_r});
    status.up_lt    = (key_r < rd_a_r);
    status.dn_lt    = (cval < key_r);
  end

  // Read ports, write port and the next values of the sift registers
  always_comb begin
    ra_a          = '0;
    ra_b          = '0;
    we            = 1'b0;
    wa            = pos_m1[AW-1:0];
    wd            = key_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    popped_nxt    = popped_r;
    was_empty_nxt = was_empty_r;
    dropped_nxt   = dropped_r;
    unique case (cmd)
      CMD_LOAD: begin
        key_nxt       = in_item.key;
        popped_nxt    = EMPTY_KEY;
        was_empty_nxt = 1'b0;
        dropped_nxt   = 1'b0;
        ra_a          = cnt_m1[AW-1:0];
        if (in_item.kind == KIND_POP) begin
          if (status.empty) begin
            was_empty_nxt = 1'b1;
          end else begin
            popped_nxt = root_r;
            cnt_nxt    = cnt_m1;
            pos_nxt    = CW'(1);
          end
        end else begin
          if (status.full) begin
            dropped_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
            pos_nxt = cnt_r + 1'b1;
          end
        end
      end
      CMD_UP_RD: begin
        ra_a = AW'(parent - 1'b1);
        we   = status.pos_root;
      end
      CMD_UP_CMP: begin
        we = 1'b1;
        if (status.up_lt) begin
          wd      = rd_a_r;
          pos_nxt = parent;
        end
      end
      CMD_DN_LAST: begin
        key_nxt = rd_a_r;
      end
      CMD_DN_RD: begin
        ra_a = left_m1[AW-1:0];
        ra_b = only_left ? left_m1[AW-1:0] : left[AW-1:0];
        we   = status.leaf;
      end
      CMD_DN_CMP: begin
        we = 1'b1;
        if (status.dn_lt) begin
          wd      = cval;
          pos_nxt = child[CW-1:0];
        end
      end
      CMD_NOP, CMD_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_r <= mem[ra_a];
    rd_b_r <= mem[ra_b];
  end

  // Mirror every write to the root slot so the minimum is always at hand
  always_ff @(posedge clk) begin
    if (we && (pos_r == CW'(1))) begin
      root_r <= wd;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    key_r       <= key_nxt;
    popped_r    <= popped_nxt;
    was_empty_r <= was_empty_nxt;
    dropped_r   <= dropped_nxt;
    if (cmd == CMD_FINISH) begin
      out_r.popped_key     <= popped_r;
      out_r.pop_was_empty  <= was_empty_r;
      out_r.insert_dropped <= dropped_r;
      out_r.current_min    <= status.empty ? EMPTY_KEY : root_r;
      out_r.entry_count    <= COUNT_W'(cnt_r);
      out_r.heap_empty     <= status.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= (cmd == CMD_FINISH);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> test/binary_min_heap_queue_test.sv
// Self-checking testbench for the binary min-heap queue: directed table, then random traffic
module binary_min_heap_queue_test;
  import bmhq_pkg::*;

  localparam int HEAP_DEPTH = 256;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

  typedef struct {
    in_item_t  op;
    bit        typed;
    out_item_t want;
  } row_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  // Shadow heap, one-based; one spare slot so a right-child index never falls off
  logic signed [KEY_W-1:0] heap_keys [1:HEAP_DEPTH+1];
  int                      heap_fill = 0;
  out_item_t               expected_results [$];
  int                      mismatches = 0;
  int                      burst_left = 0;

  binary_min_heap_queue #(.CAPACITY(HEAP_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic in_item_t op_of(logic kind, logic signed [KEY_W-1:0] key);
    in_item_t op;
    op.kind = kind;
    op.key  = key;
    return op;
  endfunction

  function automatic out_item_t result_of(logic signed [KEY_W-1:0] popped, logic was_empty,
                                          logic dropped, logic signed [KEY_W-1:0] min_key,
                                          int count, logic empty);
    out_item_t r;
    r.popped_key     = popped;
    r.pop_was_empty  = was_empty;
    r.insert_dropped = dropped;
    r.current_min    = min_key;
    r.entry_count    = COUNT_W'(count);
    r.heap_empty     = empty;
    return r;
  endfunction

  // Apply one operation to the shadow heap and return the result it yields
  function automatic out_item_t apply_heap_op(in_item_t op);
    out_item_t               r;
    int                      pos;
    int                      lc;
    int                      pick;
    logic signed [KEY_W-1:0] t;
    r.popped_key     = EMPTY_KEY;
    r.pop_was_empty  = 1'b0;
    r.insert_dropped = 1'b0;
    if (op.kind == KIND_INSERT) begin
      if (heap_fill >= HEAP_DEPTH) begin
        r.insert_dropped = 1'b1;
      end else begin
        heap_fill++;
        heap_keys[heap_fill] = op.key;
        pos = heap_fill;
        // stop at an equal parent
        while (pos > 1 && heap_keys[pos] < heap_keys[pos / 2]) begin
          t = heap_keys[pos];
          heap_keys[pos] = heap_keys[pos / 2];
          heap_keys[pos / 2] = t;
          pos = pos / 2;
        end
      end
    end else if (heap_fill == 0) begin
      r.pop_was_empty = 1'b1;
    end else begin
      r.popped_key = heap_keys[1];
      heap_keys[1] = heap_keys[heap_fill];
      heap_fill--;
      pos = 1;
      while (2 * pos <= heap_fill) begin
        lc = 2 * pos;
        // take the right child on a tie
        pick = (lc == heap_fill || heap_keys[lc] < heap_keys[lc + 1]) ? lc : lc + 1;
        if (heap_keys[pick] < heap_keys[pos]) begin
          t = heap_keys[pick];
          heap_keys[pick] = heap_keys[pos];
          heap_keys[pos] = t;
          pos = pick;
        end else begin
          break;
        end
      end
    end
    r.current_min = (heap_fill == 0) ? EMPTY_KEY : heap_keys[1];
    r.entry_count = COUNT_W'(heap_fill);
    r.heap_empty  = (heap_fill == 0);
    return r;
  endfunction

  function automatic logic signed [KEY_W-1:0] draw_key();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return KEY_MIN;
          1: return KEY_MAX;
          2: return EMPTY_KEY;
          default: return '0;
        endcase
      end
      1, 2, 3: return KEY_W'(int'($urandom_range(0, 8)) - 4);
      default: return $urandom();
    endcase
  endfunction

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic compare_result(out_item_t want, out_item_t got);
    if (got.popped_key !== want.popped_key)
      log_mismatch($sformatf("popped_key expected %0d got %0d", want.popped_key, got.popped_key));
    if (got.pop_was_empty !== want.pop_was_empty)
      log_mismatch($sformatf("pop_was_empty expected %0b got %0b",
                             want.pop_was_empty, got.pop_was_empty));
    if (got.insert_dropped !== want.insert_dropped)
      log_mismatch($sformatf("insert_dropped expected %0b got %0b",
                             want.insert_dropped, got.insert_dropped));
    if (got.current_min !== want.current_min)
      log_mismatch($sformatf("current_min expected %0d got %0d",
                             want.current_min, got.current_min));
    if (got.entry_count !== want.entry_count)
      log_mismatch($sformatf("entry_count expected %0d got %0d",
                             want.entry_count, got.entry_count));
    if (got.heap_empty !== want.heap_empty)
      log_mismatch($sformatf("heap_empty expected %0b got %0b", want.heap_empty, got.heap_empty));
  endtask

  // Result monitor: the receiver never stalls, so every strobe is a transaction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0)
        log_mismatch($sformatf("unexpected result, popped_key %0d count %0d",
                               out_item.popped_key, out_item.entry_count));
      else
        compare_result(expected_results.pop_front(), out_item);
    end
  end

  // Present one operation, hold it until taken, then either idle for a drawn gap or go on back to back
  task automatic send_op(in_item_t op, bit typed, out_item_t want);
    out_item_t predicted;
    int        gap;
    start   <= 1'b1;
    in_item <= op;
    do @(posedge clk); while (busy);
    predicted = apply_heap_op(op);
    expected_results.insert(expected_results.size(), typed ? want : predicted);
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(10, 40);
    end else begin
      gap = $urandom_range(0, 14);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    row_t directed_rows [$];
    int   wait_cycles;

    directed_rows = '{
      '{op_of(KIND_POP, '0), 1'b1, result_of(EMPTY_KEY, 1'b1, 1'b0, EMPTY_KEY, 0, 1'b1)},
      '{op_of(KIND_INSERT, KEY_MAX), 1'b1, result_of(EMPTY_KEY, 1'b0, 1'b0, KEY_MAX, 1, 1'b0)},
      '{op_of(KIND_INSERT, KEY_MIN), 1'b1, result_of(EMPTY_KEY, 1'b0, 1'b0, KEY_MIN, 2, 1'b0)},
      '{op_of(KIND_POP, 32'sh1234_5678), 1'b1, result_of(KEY_MIN, 1'b0, 1'b0, KEY_MAX, 1, 1'b0)},
      '{op_of(KIND_POP, '1), 1'b1, result_of(KEY_MAX, 1'b0, 1'b0, EMPTY_KEY, 0, 1'b1)},
      '{op_of(KIND_POP, KEY_MAX), 1'b1, result_of(EMPTY_KEY, 1'b1, 1'b0, EMPTY_KEY, 0, 1'b1)},
      // a stored -1 must not read as an empty pop
      '{op_of(KIND_INSERT, EMPTY_KEY), 1'b1,
        result_of(EMPTY_KEY, 1'b0, 1'b0, EMPTY_KEY, 1, 1'b0)},
      '{op_of(KIND_POP, '0), 1'b1, result_of(EMPTY_KEY, 1'b0, 1'b0, EMPTY_KEY, 0, 1'b1)},
      // equal keys on both sift directions
      '{op_of(KIND_INSERT, 32'sd5), 1'b0, '0},
      '{op_of(KIND_INSERT, 32'sd5), 1'b0, '0},
      '{op_of(KIND_INSERT, 32'sd5), 1'b0, '0},
      '{op_of(KIND_INSERT, 32'sd3), 1'b0, '0},
      '{op_of(KIND_INSERT, 32'sd5), 1'b0, '0},
      '{op_of(KIND_INSERT, 32'sd3), 1'b0, '0},
      '{op_of(KIND_INSERT, 32'sd4), 1'b0, '0},
      '{op_of(KIND_POP, '0), 1'b0, '0},
      '{op_of(KIND_POP, '1), 1'b0, '0},
      '{op_of(KIND_POP, '0), 1'b0, '0},
      '{op_of(KIND_POP, 32'sh5555_5555), 1'b0, '0},
      '{op_of(KIND_POP, '0), 1'b0, '0},
      '{op_of(KIND_POP, '0), 1'b0, '0},
      '{op_of(KIND_POP, '0), 1'b0, '0},
      '{op_of(KIND_POP, '0), 1'b1, result_of(EMPTY_KEY, 1'b1, 1'b0, EMPTY_KEY, 0, 1'b1)},
      '{op_of(KIND_INSERT, '0), 1'b1, result_of(EMPTY_KEY, 1'b0, 1'b0, '0, 1, 1'b0)},
      '{op_of(KIND_POP, '0), 1'b1, result_of('0, 1'b0, 1'b0, EMPTY_KEY, 0, 1'b1)}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_op(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].want);

    // insert-heavy mix to build deep heaps
    repeat (300)
      send_op(op_of(($urandom_range(0, 9) < 6) ? KIND_INSERT : KIND_POP, draw_key()), 1'b0, '0);

    // hold off until the block has drained everything in flight
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);

    // fill to capacity, push past it, then drain past empty
    while (heap_fill < HEAP_DEPTH)
      send_op(op_of(KIND_INSERT, draw_key()), 1'b0, '0);
    repeat (4)
      send_op(op_of(KIND_INSERT, draw_key()), 1'b0, '0);
    while (heap_fill > 0)
      send_op(op_of(KIND_POP, $urandom()), 1'b0, '0);
    repeat (2)
      send_op(op_of(KIND_POP, $urandom()), 1'b0, '0);

    // pop-leaning mix keeps the heap shallow and hits empty pops
    repeat (270)
      send_op(op_of(($urandom_range(0, 19) < 9) ? KIND_INSERT : KIND_POP, draw_key()), 1'b0, '0);

    start <= 1'b0;
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 200) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (25) @(posedge clk);
    if (expected_results.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
